/* design/fol_pkg.sv */
package fol_pkg;

   localparam int CAPACITY_DEF = 32;
   localparam int MAX_RESULTS  = 32;
   localparam int COUNT_SAT    = 63;

   localparam logic [3:0] FN_APPEND  = 4'd0;
   localparam logic [3:0] FN_INSERT  = 4'd1;
   localparam logic [3:0] FN_REFRESH = 4'd2;
   localparam logic [3:0] FN_RM_GRP  = 4'd3;
   localparam logic [3:0] FN_RM_ID   = 4'd4;
   localparam logic [3:0] FN_COUNT   = 4'd5;
   localparam logic [3:0] FN_TRIM    = 4'd6;
   localparam logic [3:0] FN_CLEAR   = 4'd7;
   localparam logic [3:0] FN_READ    = 4'd8;
   localparam logic [3:0] FN_SUMMARY = 4'd9;
   localparam logic [3:0] FN_MARK    = 4'd10;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NONE    = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_NO_ANS  = 2'd3;

   typedef struct packed {
      logic [3:0]  func;
      logic [62:0] feed_id;
      logic [30:0] stamp;
      logic [30:0] actor;
      logic [62:0] merge_key;
      logic [15:0] small_type;
      logic [30:0] item_type;
      logic        whole_group;
   } req_type;

   typedef struct packed {
      logic [62:0] out_feed_id;
      logic [30:0] out_stamp;
      logic [30:0] out_actor;
      logic [62:0] out_merge_key;
      logic [15:0] out_small_type;
      logic [30:0] out_item_type;
      logic [5:0]  count;
      logic [1:0]  status;
      logic        loaded_flag;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [62:0] id;
      logic [30:0] stamp;
      logic [30:0] actor;
      logic [62:0] merge;
      logic [15:0] small_type;
      logic [30:0] itype;
   } row_type;

   function automatic row_type req_to_row(req_type r);
      row_type w;
      w.id         = r.feed_id;
      w.stamp      = r.stamp;
      w.actor      = r.actor;
      w.merge      = r.merge_key;
      w.small_type = r.small_type;
      w.itype      = r.item_type;
      return w;
   endfunction

   function automatic rsp_type row_to_rsp(row_type w, logic last);
      rsp_type o;
      o                = '0;
      o.out_feed_id    = w.id;
      o.out_stamp      = w.stamp;
      o.out_actor      = w.actor;
      o.out_merge_key  = w.merge;
      o.out_small_type = w.small_type;
      o.out_item_type  = w.itype;
      o.last           = last;
      return o;
   endfunction

   function automatic rsp_type status_rsp(logic [1:0] st, logic [5:0] cnt);
      rsp_type o;
      o        = '0;
      o.status = st;
      o.count  = cnt;
      o.last   = 1'b1;
      return o;
   endfunction

endpackage

/* design/fol_mem.sv */
module fol_mem
   import fol_pkg::*;
#(
   parameter int DEPTH = CAPACITY_DEF,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  row_type       wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output row_type       rd_data
);

   row_type mem [DEPTH];
   row_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

/* design/fol_ctrl.sv */
module fol_ctrl
   import fol_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   localparam int AW = $clog2(CAPACITY),
   localparam int SW = $clog2(CAPACITY + 1),
   localparam int CW = (SW > 6) ? SW : 6
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data,
   input  logic          csr_wr_en,
   input  logic [5:0]    csr_wr_data,
   output logic          mem_wr_en,
   output logic [AW-1:0] mem_wr_addr,
   output row_type       mem_wr_data,
   output logic          mem_rd_en,
   output logic [AW-1:0] mem_rd_addr,
   input  row_type       mem_rd_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_START, S_SC_RD, S_SC_EV, S_SH_RD, S_SH_WR, S_RM_RD, S_RM_EV,
      S_RM_END, S_CT_RD, S_CT_EV, S_RA_RD, S_RA_EV, S_FIN
   } state_type;

   state_type   state_ff, state_in;
   req_type     op_ff, op_in;
   logic [SW-1:0] size_ff, size_in;
   logic [62:0] hi_ff, hi_in;
   logic [30:0] old_ff, old_in;
   logic        loaded_ff, loaded_in;
   logic [5:0]  keep_ff;
   logic [SW-1:0] idx_ff, idx_in;
   logic [SW-1:0] wp_ff, wp_in;
   logic [SW-1:0] pos_ff, pos_in;
   logic        posf_ff, posf_in;
   row_type     tgt_ff, tgt_in;
   logic [15:0] key_st_ff, key_st_in;
   logic [62:0] key_mk_ff, key_mk_in;
   logic        single_ff, single_in;
   logic        done1_ff, done1_in;
   row_type     pend_ff, pend_in;
   logic        pendv_ff, pendv_in;
   logic [5:0]  nout_ff, nout_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [1:0]  fst_ff, fst_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rspv_ff, rspv_in;

   row_type     d;
   logic        emit_ok, emit;
   rsp_type     emit_data;
   logic        full, match, ra_last, pos_now;
   logic [CW-1:0] limit;
   logic [SW-1:0] pos_sel;

   assign d         = mem_rd_data;
   assign emit_ok   = !rspv_ff || !rsp_stall;
   assign full      = size_ff >= SW'(CAPACITY);
   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rspv_ff;
   assign rsp_data  = rsp_ff;
   assign limit     = (CW'(size_ff) < CW'(MAX_RESULTS)) ? CW'(size_ff) : CW'(MAX_RESULTS);
   assign ra_last   = CW'(idx_ff) + CW'(1) == limit;
   assign match     = single_ff ? (d.id == op_ff.feed_id && !done1_ff)
                                : (d.small_type == key_st_ff && d.merge == key_mk_ff);
   assign pos_now   = posf_ff || (op_ff.stamp >= d.stamp);
   assign pos_sel   = posf_ff ? pos_ff : idx_ff;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      size_in   = size_ff;
      hi_in     = hi_ff;
      old_in    = old_ff;
      loaded_in = loaded_ff;
      idx_in    = idx_ff;
      wp_in     = wp_ff;
      pos_in    = pos_ff;
      posf_in   = posf_ff;
      tgt_in    = tgt_ff;
      key_st_in = key_st_ff;
      key_mk_in = key_mk_ff;
      single_in = single_ff;
      done1_in  = done1_ff;
      pend_in   = pend_ff;
      pendv_in  = pendv_ff;
      nout_in   = nout_ff;
      cnt_in    = cnt_ff;
      fst_in    = fst_ff;
      emit      = 1'b0;
      emit_data = '0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = '0;
      mem_wr_data = '0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_data;
               state_in = S_START;
            end
         end
         S_START: begin
            idx_in   = '0;
            posf_in  = 1'b0;
            cnt_in   = '0;
            wp_in    = '0;
            pendv_in = 1'b0;
            nout_in  = '0;
            done1_in = 1'b0;
            case (op_ff.func)
               FN_APPEND, FN_INSERT: begin
                  tgt_in = req_to_row(op_ff);
                  if (full) begin
                     if (emit_ok) begin
                        emit      = 1'b1;
                        emit_data = status_rsp(ST_FULL, '0);
                        state_in  = S_IDLE;
                     end
                  end else if (op_ff.func == FN_INSERT) begin
                     state_in = S_SC_RD;
                  end else if (emit_ok) begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = size_ff[AW-1:0];
                     mem_wr_data = req_to_row(op_ff);
                     size_in     = size_ff + SW'(1);
                     hi_in       = (op_ff.feed_id > hi_ff) ? op_ff.feed_id : hi_ff;
                     old_in      = (op_ff.stamp < old_ff) ? op_ff.stamp : old_ff;
                     emit        = 1'b1;
                     emit_data   = status_rsp(ST_OK, '0);
                     state_in    = S_IDLE;
                  end
               end
               FN_REFRESH, FN_RM_ID: state_in = S_SC_RD;
               FN_RM_GRP: begin
                  key_st_in = op_ff.small_type;
                  key_mk_in = op_ff.merge_key;
                  single_in = 1'b0;
                  state_in  = S_RM_RD;
               end
               FN_COUNT: begin
                  if (size_ff == '0) begin
                     fst_in   = ST_OK;
                     state_in = S_FIN;
                  end else begin
                     state_in = S_CT_RD;
                  end
               end
               FN_READ: begin
                  if (size_ff == '0) begin
                     fst_in   = ST_NONE;
                     state_in = S_FIN;
                  end else begin
                     state_in = S_RA_RD;
                  end
               end
               default: begin
                  if (emit_ok) begin
                     emit     = 1'b1;
                     state_in = S_IDLE;
                     case (op_ff.func)
                        FN_TRIM: begin
                           if (CW'(size_ff) > CW'(keep_ff)) begin
                              size_in   = SW'(keep_ff);
                              loaded_in = 1'b0;
                              emit_data = status_rsp(ST_OK, '0);
                           end else begin
                              emit_data = status_rsp(ST_NONE, '0);
                           end
                        end
                        FN_CLEAR: begin
                           size_in   = '0;
                           emit_data = status_rsp(ST_OK, '0);
                        end
                        FN_SUMMARY: begin
                           emit_data = status_rsp(ST_OK,
                              (CW'(size_ff) > CW'(COUNT_SAT)) ? 6'(COUNT_SAT)
                                                              : 6'(size_ff));
                           emit_data.out_feed_id = hi_ff;
                           emit_data.out_stamp   = old_ff;
                           emit_data.loaded_flag = loaded_ff;
                        end
                        FN_MARK: begin
                           loaded_in = 1'b1;
                           emit_data = status_rsp(ST_OK, '0);
                        end
                        default: emit_data = status_rsp(ST_NONE, '0);
                     endcase
                  end
               end
            endcase
         end
         S_SC_RD: begin
            if (idx_ff == size_ff) begin
               case (op_ff.func)
                  FN_INSERT: begin
                     pos_in   = size_ff;
                     wp_in    = size_ff;
                     state_in = S_SH_RD;
                  end
                  FN_RM_ID: begin
                     key_st_in = '0;
                     key_mk_in = '0;
                     single_in = 1'b0;
                     idx_in    = '0;
                     state_in  = S_RM_RD;
                  end
                  FN_COUNT: begin
                     fst_in   = ST_OK;
                     state_in = S_FIN;
                  end
                  default: begin
                     fst_in   = ST_NONE;
                     state_in = S_FIN;
                  end
               endcase
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = idx_ff[AW-1:0];
               state_in    = S_SC_EV;
            end
         end
         S_SC_EV: begin
            idx_in   = idx_ff + SW'(1);
            state_in = S_SC_RD;
            case (op_ff.func)
               FN_INSERT: begin
                  if (op_ff.stamp >= d.stamp) begin
                     pos_in   = idx_ff;
                     wp_in    = size_ff;
                     state_in = S_SH_RD;
                  end
               end
               FN_REFRESH: begin
                  posf_in = pos_now;
                  pos_in  = pos_sel;
                  if (d.id == op_ff.feed_id) begin
                     if (pos_now) begin
                        tgt_in       = d;
                        tgt_in.stamp = op_ff.stamp;
                        wp_in        = idx_ff;
                        state_in     = S_SH_RD;
                     end else begin
                        fst_in   = ST_NONE;
                        state_in = S_FIN;
                     end
                  end
               end
               FN_RM_ID: begin
                  if (d.id == op_ff.feed_id) begin
                     key_st_in = d.small_type;
                     key_mk_in = d.merge;
                     single_in = !op_ff.whole_group;
                     idx_in    = '0;
                     state_in  = S_RM_RD;
                  end
               end
               FN_COUNT: begin
                  if (d.id <= op_ff.feed_id) begin
                     fst_in   = ST_OK;
                     state_in = S_FIN;
                  end else if (d.actor != op_ff.actor && cnt_ff < 6'(COUNT_SAT)) begin
                     cnt_in = cnt_ff + 6'd1;
                  end
               end
               default: begin
                  fst_in   = ST_NONE;
                  state_in = S_FIN;
               end
            endcase
         end
         S_SH_RD: begin
            if (wp_ff == pos_ff) begin
               if (emit_ok) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = pos_ff[AW-1:0];
                  mem_wr_data = tgt_ff;
                  if (op_ff.func == FN_INSERT) begin
                     size_in = size_ff + SW'(1);
                     hi_in   = (op_ff.feed_id > hi_ff) ? op_ff.feed_id : hi_ff;
                  end
                  emit      = 1'b1;
                  emit_data = status_rsp(ST_OK, '0);
                  state_in  = S_IDLE;
               end
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = AW'(wp_ff - SW'(1));
               state_in    = S_SH_WR;
            end
         end
         S_SH_WR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = wp_ff[AW-1:0];
            mem_wr_data = d;
            wp_in       = wp_ff - SW'(1);
            state_in    = S_SH_RD;
         end
         S_RM_RD: begin
            if (idx_ff == size_ff) begin
               size_in  = wp_ff;
               state_in = S_RM_END;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = idx_ff[AW-1:0];
               state_in    = S_RM_EV;
            end
         end
         S_RM_EV: begin
            if (match) begin
               if (!(nout_ff < 6'(MAX_RESULTS) && pendv_ff && !emit_ok)) begin
                  if (nout_ff < 6'(MAX_RESULTS)) begin
                     emit      = pendv_ff;
                     emit_data = row_to_rsp(pend_ff, 1'b0);
                     pend_in   = d;
                     pendv_in  = 1'b1;
                     nout_in   = nout_ff + 6'd1;
                  end
                  done1_in = 1'b1;
                  idx_in   = idx_ff + SW'(1);
                  state_in = S_RM_RD;
               end
            end else begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = wp_ff[AW-1:0];
               mem_wr_data = d;
               wp_in       = wp_ff + SW'(1);
               idx_in      = idx_ff + SW'(1);
               state_in    = S_RM_RD;
            end
         end
         S_RM_END: begin
            if (pendv_ff) begin
               if (emit_ok) begin
                  emit      = 1'b1;
                  emit_data = row_to_rsp(pend_ff, 1'b1);
                  pendv_in  = 1'b0;
                  state_in  = S_IDLE;
               end
            end else begin
               fst_in   = ST_NONE;
               state_in = S_FIN;
            end
         end
         S_CT_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = AW'(size_ff - SW'(1));
            state_in    = S_CT_EV;
         end
         S_CT_EV: begin
            if (d.id > op_ff.feed_id) begin
               fst_in   = ST_NO_ANS;
               state_in = S_FIN;
            end else begin
               state_in = S_SC_RD;
            end
         end
         S_RA_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = idx_ff[AW-1:0];
            state_in    = S_RA_EV;
         end
         S_RA_EV: begin
            if (emit_ok) begin
               emit      = 1'b1;
               emit_data = row_to_rsp(d, ra_last);
               idx_in    = idx_ff + SW'(1);
               state_in  = ra_last ? S_IDLE : S_RA_RD;
            end
         end
         S_FIN: begin
            if (emit_ok) begin
               emit      = 1'b1;
               emit_data = status_rsp(fst_ff, cnt_ff);
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      rsp_in  = emit ? emit_data : rsp_ff;
      rspv_in = emit ? 1'b1 : (rspv_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         size_ff   <= '0;
         hi_ff     <= '0;
         old_ff    <= '1;
         loaded_ff <= 1'b0;
         keep_ff   <= 6'd32;
         rspv_ff   <= 1'b0;
         pendv_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         size_ff   <= size_in;
         hi_ff     <= hi_in;
         old_ff    <= old_in;
         loaded_ff <= loaded_in;
         rspv_ff   <= rspv_in;
         pendv_ff  <= pendv_in;
         if (csr_wr_en) begin
            keep_ff <= csr_wr_data;
         end
      end
      op_ff     <= op_in;
      idx_ff    <= idx_in;
      wp_ff     <= wp_in;
      pos_ff    <= pos_in;
      posf_ff   <= posf_in;
      tgt_ff    <= tgt_in;
      key_st_ff <= key_st_in;
      key_mk_ff <= key_mk_in;
      single_ff <= single_in;
      done1_ff  <= done1_in;
      pend_ff   <= pend_in;
      nout_ff   <= nout_in;
      cnt_ff    <= cnt_in;
      fst_ff    <= fst_in;
      rsp_ff    <= rsp_in;
   end

   a_size_bound: assert property (@(posedge clock) disable iff (reset)
      size_ff <= SW'(CAPACITY))
      else $error("list size above capacity");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit |-> (!rspv_ff || !rsp_stall))
      else $error("result register overwritten");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !mem_wr_en)
      else $error("memory write while idle");

   a_wr_addr: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (SW'(mem_wr_addr) < SW'(CAPACITY)))
      else $error("memory write out of range");

endmodule

/* design/time_ordered_feed_list.sv */
// Time ordered feed list: up to CAPACITY entries, newest time first.
// Request channel (req_valid / req_stall / req_data) carries one operation
// word; func selects append, insert, refresh, removals, unread count, trim,
// clear, read all, summary or mark loaded. Result channel (rsp_valid /
// rsp_stall / rsp_data) returns one or more words per operation, the final
// one with last set. csr_wr_en / csr_wr_data write the keep count.
// Entries live in a one-port-read, one-port-write memory with registered
// read data; one operation is handled at a time.
// Scans read, then evaluate, each entry visited; moving an entry in insert
// or refresh reads, then writes, each row shifted.
// Reset clears the list size, highest id, the all-loaded mark, sets the
// oldest time to all ones and the keep count to 32; entry contents are left.
// A stalled result word holds in the output register; the block keeps
// working on the next operation until it has another word to send.
module time_ordered_feed_list
   import fol_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_wr_en,
   input  logic [5:0] csr_wr_data
);

   localparam int AW = $clog2(CAPACITY);

   // memory ports
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   row_type       wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   row_type       rd_data;

   // sequencer: scans, shifts and compacts the entry memory
   fol_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mem_wr_en   (wr_en),
      .mem_wr_addr (wr_addr),
      .mem_wr_data (wr_data),
      .mem_rd_en   (rd_en),
      .mem_rd_addr (rd_addr),
      .mem_rd_data (rd_data)
   );

   // entry storage, one row per list slot
   fol_mem #(.DEPTH(CAPACITY)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

/* tb/tb_time_ordered_feed_list.sv */
module tb_time_ordered_feed_list;
   import fol_pkg::*;

   localparam int CAP        = 32;
   // no word accepted on either side for this many cycles ends the run
   localparam int IDLE_LIMIT = 20000;
   // settle cycles once nothing is outstanding
   localparam int DRAIN_WAIT = 300;

   // one stored list entry, laid out as the block keeps it
   typedef struct packed {
      logic [62:0] id;
      logic [30:0] stamp;
      logic [30:0] actor;
      logic [62:0] merge;
      logic [15:0] small_type;
      logic [30:0] itype;
   } entry_t;

   // ---------------------------------------------------------------------
   // Feed list scoreboard: own copy of the list, predicts the answer words
   // of every accepted operation and checks returned words against them.
   // ---------------------------------------------------------------------
   class feed_list_scoreboard;
      entry_t      rows[$];
      logic [62:0] top_id;
      logic [30:0] low_stamp;
      logic        loaded;
      logic [5:0]  keep;
      rsp_type     pending[$];
      int          mismatches;

      function void clear_state();
         rows.delete();
         pending.delete();
         top_id     = '0;
         low_stamp  = '1;
         loaded     = 1'b0;
         keep       = 6'd32;
         mismatches = 0;
      endfunction

      function void set_keep(logic [5:0] v);
         keep = v;
      endfunction

      function rsp_type word_of(entry_t e);
         rsp_type o;
         o                = '0;
         o.out_feed_id    = e.id;
         o.out_stamp      = e.stamp;
         o.out_actor      = e.actor;
         o.out_merge_key  = e.merge;
         o.out_small_type = e.small_type;
         o.out_item_type  = e.itype;
         return o;
      endfunction

      function void push_status(logic [1:0] st, logic [5:0] cnt);
         rsp_type o;
         o        = '0;
         o.status = st;
         o.count  = cnt;
         o.last   = 1'b1;
         pending = {pending, o};
      endfunction

      // take out every entry of a group, listing up to MAX_RESULTS of them in list order
      function void drop_group(logic [15:0] st, logic [62:0] mk);
         entry_t  kept[$];
         int      n;
         n = 0;
         foreach (rows[i]) begin
            if (rows[i].small_type == st && rows[i].merge == mk) begin
               if (n < MAX_RESULTS) begin
                  pending = {pending, word_of(rows[i])};
                  n++;
               end
            end else begin
               kept = {kept, rows[i]};
            end
         end
         rows = kept;
         if (n == 0) begin
            push_status(ST_NONE, 6'd0);
         end else begin
            pending[pending.size() - 1].last = 1'b1;
         end
      endfunction

      // note one accepted operation
      function void note_request(req_type r);
         entry_t  e;
         rsp_type o;
         int      pos, hit, cnt, found;
         e.id = r.feed_id;  e.stamp = r.stamp;  e.actor = r.actor;
         e.merge = r.merge_key;  e.small_type = r.small_type;  e.itype = r.item_type;
         case (r.func)
            FN_APPEND, FN_INSERT: begin
               if (rows.size() >= CAP) begin
                  push_status(ST_FULL, 6'd0);
               end else begin
                  if (r.feed_id > top_id) top_id = r.feed_id;
                  if (r.func == FN_APPEND) begin
                     rows = {rows, e};
                     if (r.stamp < low_stamp) low_stamp = r.stamp;
                  end else begin
                     pos = rows.size();
                     foreach (rows[i])
                        if (pos == rows.size() && r.stamp >= rows[i].stamp) pos = i;
                     rows.insert(pos, e);
                  end
                  push_status(ST_OK, 6'd0);
               end
            end
            FN_REFRESH: begin
               pos = -1;  hit = -1;
               foreach (rows[i]) begin
                  if (hit < 0) begin
                     if (pos < 0 && r.stamp >= rows[i].stamp) pos = i;
                     if (rows[i].id == r.feed_id) hit = i;
                  end
               end
               if (pos < 0 || hit < 0) begin
                  push_status(ST_NONE, 6'd0);
               end else begin
                  e = rows[hit];
                  e.stamp = r.stamp;
                  rows.delete(hit);
                  rows.insert(pos, e);
                  push_status(ST_OK, 6'd0);
               end
            end
            FN_RM_GRP: drop_group(r.small_type, r.merge_key);
            FN_RM_ID: begin
               found = -1;
               foreach (rows[i])
                  if (found < 0 && rows[i].id == r.feed_id) found = i;
               if (found < 0) begin
                  drop_group(16'd0, 63'd0);
               end else if (!r.whole_group) begin
                  o      = word_of(rows[found]);
                  o.last = 1'b1;
                  pending = {pending, o};
                  rows.delete(found);
               end else begin
                  drop_group(rows[found].small_type, rows[found].merge);
               end
            end
            FN_COUNT: begin
               cnt = 0;
               if (rows.size() > 0 && rows[rows.size()-1].id > r.feed_id) begin
                  push_status(ST_NO_ANS, 6'd0);
               end else begin
                  found = 0;
                  foreach (rows[i]) begin
                     if (rows[i].id <= r.feed_id) found = 1;
                     if (!found && rows[i].actor != r.actor && cnt < COUNT_SAT) cnt++;
                  end
                  push_status(ST_OK, 6'(cnt));
               end
            end
            FN_TRIM: begin
               if (rows.size() > keep) begin
                  while (rows.size() > keep) rows.delete(rows.size() - 1);
                  loaded = 1'b0;
                  push_status(ST_OK, 6'd0);
               end else begin
                  push_status(ST_NONE, 6'd0);
               end
            end
            FN_CLEAR: begin
               rows.delete();
               push_status(ST_OK, 6'd0);
            end
            FN_READ: begin
               if (rows.size() == 0) begin
                  push_status(ST_NONE, 6'd0);
               end else begin
                  foreach (rows[i]) begin
                     o      = word_of(rows[i]);
                     o.last = (i == rows.size() - 1);
                     pending = {pending, o};
                  end
               end
            end
            FN_SUMMARY: begin
               o             = '0;
               o.out_feed_id = top_id;
               o.out_stamp   = low_stamp;
               o.count       = 6'(rows.size());
               o.loaded_flag = loaded;
               o.last        = 1'b1;
               pending = {pending, o};
            end
            FN_MARK: begin
               loaded = 1'b1;
               push_status(ST_OK, 6'd0);
            end
            default: push_status(ST_NONE, 6'd0);
         endcase
      endfunction

      // compare one returned word with the oldest prediction
      function void check_word(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected %h actual %h", want, got);
         end
      endfunction
   endclass

   logic       clock, reset;
   logic       req_valid, req_stall;
   req_type    req_data;
   logic       rsp_valid, rsp_stall;
   rsp_type    rsp_data;
   logic       csr_wr_en;
   logic [5:0] csr_wr_data;

   feed_list_scoreboard board;
   int  send_idle_pct, recv_stall_pct;
   int  quiet_cycles;

   // pool of ids so refresh / remove / count hit existing entries often
   logic [62:0] used_ids[$];

   time_ordered_feed_list dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // result side: random stall, check every accepted word
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) board.check_word(rsp_data);
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // watchdog: cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // random gap, then present one word and hold it until accepted;
   // valid stays up so the next word can follow on the next edge
   task automatic send_word(req_type r);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(r);
   endtask

   task automatic stop_sending();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      stop_sending();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // keep count changes only with the block idle
   task automatic write_keep(logic [5:0] v);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      board.set_keep(v);
   endtask

   function automatic logic [62:0] rand63();
      return 63'({$urandom(), $urandom()});
   endfunction

   // build one random word; small key/type ranges so groups collide
   function automatic req_type random_word(logic [3:0] fn);
      req_type r;
      r.func       = fn;
      r.stamp      = ($urandom_range(3) == 0) ? 31'($urandom()) : 31'($urandom_range(40));
      r.actor      = ($urandom_range(7) == 0) ? 31'($urandom()) : 31'($urandom_range(3));
      r.merge_key  = ($urandom_range(7) == 0) ? rand63() : 63'($urandom_range(3));
      r.small_type = ($urandom_range(7) == 0) ? 16'($urandom()) : 16'($urandom_range(2));
      r.item_type  = 31'($urandom());
      r.whole_group = 1'($urandom_range(1));
      if (used_ids.size() > 0 && $urandom_range(3) != 0)
         r.feed_id = used_ids[$urandom_range(used_ids.size() - 1)];
      else if ($urandom_range(3) == 0)
         r.feed_id = rand63();
      else
         r.feed_id = 63'($urandom_range(200));
      if (fn == FN_APPEND || fn == FN_INSERT) used_ids = {used_ids, r.feed_id};
      if (used_ids.size() > 64) void'(used_ids.pop_front());
      return r;
   endfunction

   task automatic random_phase(int items);
      int      pick;
      req_type r;
      for (int k = 0; k < items; k++) begin
         pick = $urandom_range(99);
         // fills a little under half the time, else any other operation or an unused func code
         if (pick < 25)      r = random_word(FN_APPEND);
         else if (pick < 45) r = random_word(FN_INSERT);
         else if (pick < 97) r = random_word(4'($urandom_range(2, 10)));
         else                r = random_word(4'($urandom_range(11, 15)));
         send_word(r);
      end
   endtask

   initial begin
      req_type r;
      board = new();
      board.clear_state();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty-list corners first
      send_word(random_word(FN_READ));
      send_word(random_word(FN_COUNT));
      send_word(random_word(FN_SUMMARY));
      r = random_word(FN_RM_ID);  r.feed_id = 63'h7FFF_FFFF_FFFF_FFFF;
      send_word(r);
      // extremes of the fields
      r = '1;  r.func = FN_APPEND;  r.whole_group = 1'b1;
      send_word(r);
      r = '0;  r.func = FN_INSERT;
      send_word(r);
      r = '0;  r.func = FN_INSERT;  r.feed_id = 63'd5;  r.stamp = 31'd10;
      send_word(r);
      r = random_word(FN_REFRESH); r.feed_id = 63'd5;  r.stamp = 31'h7FFF_FFFF;
      send_word(r);
      r = random_word(FN_REFRESH); r.feed_id = 63'd999; send_word(r);
      r = '0;  r.func = FN_COUNT;  r.feed_id = 63'h7FFF_FFFF_FFFF_FFFF;  r.actor = '1;
      send_word(r);
      r = '0;  r.func = FN_COUNT;  r.feed_id = 63'd1;
      send_word(r);
      send_word(random_word(FN_MARK));
      send_word(random_word(FN_SUMMARY));
      // remove id with no match drops the zero group
      r = '0;  r.func = FN_RM_ID;  r.feed_id = 63'd12345;
      send_word(r);
      r = '1;  r.func = FN_RM_GRP;
      send_word(r);
      r = '0;  r.func = FN_INSERT;  r.feed_id = 63'd7;  r.merge_key = 63'd1;
      send_word(r);
      r.func = FN_RM_ID;  r.whole_group = 1'b1;
      send_word(r);
      r = '0;  r.func = 4'd11;  send_word(r);
      r = '1;  send_word(r);
      // fill past capacity to see the full-list drop, then read it all
      for (int k = 0; k < CAP + 2; k++) send_word(random_word(FN_APPEND));
      send_word(random_word(FN_READ));
      send_word(random_word(FN_TRIM));
      send_word(random_word(FN_CLEAR));

      write_keep(6'd0);
      send_idle_pct = 59;
      random_phase(80);
      send_word(random_word(FN_TRIM));

      write_keep(6'd63);
      send_idle_pct = 0;  recv_stall_pct = 59;
      random_phase(80);

      // sender holds off until everything is back
      wait_drained();
      write_keep(6'd5);
      send_idle_pct = 27;  recv_stall_pct = 27;
      random_phase(80);

      write_keep(6'd32);
      send_idle_pct = 0;  recv_stall_pct = 0;
      random_phase(80);

      write_keep(6'($urandom_range(1, 31)));
      send_idle_pct = 59;  recv_stall_pct = 59;
      random_phase(40);

      wait_drained();
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

/* sim.f */
design/fol_pkg.sv
design/fol_mem.sv
design/fol_ctrl.sv
design/time_ordered_feed_list.sv
tb/tb_time_ordered_feed_list.sv
